// ----- hdl/fiodec_ascii_case_shift_translator_macros.svh -----
// ----------------------------------------------------------------------------
// fiodec translator assertion macros
// shared property wrappers for the translator's checks
// ----------------------------------------------------------------------------
`ifndef FIODEC_ASCII_CASE_SHIFT_TRANSLATOR_MACROS_SVH
`define FIODEC_ASCII_CASE_SHIFT_TRANSLATOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define FIODEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define FIODEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fiodec_pkg.sv -----
// ----------------------------------------------------------------------------
// fiodec translator package
// code constants, result type and the key and print translation tables
// ----------------------------------------------------------------------------
package fiodec_pkg;

  // fiodec shift codes
  localparam logic [5:0] SHIFT_UP_CODE   = 6'o74;
  localparam logic [5:0] SHIFT_DOWN_CODE = 6'o72;

  // ascii keys and printer characters
  localparam logic [6:0] KEY_RUBOUT    = 7'o177;
  localparam logic [6:0] KEY_BACKSPACE = 7'o010;
  localparam logic [6:0] CHAR_CR       = 7'h0d;
  localparam logic [6:0] CHAR_LF       = 7'h0a;

  // operation and result kind codes
  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_PRINT = 1'b1;
  localparam logic KIND_FIODEC = 1'b0;
  localparam logic KIND_ASCII  = 1'b1;

  // key table entry: bit 7 either case, bit 6 upper case, bits 5..0 code
  localparam int KEY_ANY_BIT = 7;
  localparam int KEY_UP_BIT  = 6;

  typedef struct packed {
    logic       kind;
    logic [6:0] value;
    logic       last;
  } result_t;

  // ascii key to fiodec code with case class, zero means untranslatable
  localparam logic [7:0] KEY_ROM [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hbd, 8'h9e, 8'h00, 8'h00, 8'h00, 8'hbf, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h80, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h46, 8'h42,
    8'h2f, 8'h2d, 8'h7b, 8'h6c, 8'h1b, 8'h2c, 8'h3b, 8'h11,
    8'h10, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h00, 8'h00, 8'h47, 8'h5b, 8'h48, 8'h51,
    8'h20, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
    8'h67, 8'h68, 8'h69, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56,
    8'h57, 8'h58, 8'h59, 8'h6f, 8'h2e, 8'h6d, 8'h49, 8'h60,
    8'h50, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h00, 8'h6e, 8'h00, 8'h43, 8'hbd
  };

  // {case, fiodec code} to ascii, zero means no glyph
  localparam logic [6:0] PRINT_ROM [128] = '{
    7'h20, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h30, 7'h2f, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78,
    7'h79, 7'h7a, 7'h00, 7'h2c, 7'h00, 7'h00, 7'h09, 7'h00,
    7'h40, 7'h6a, 7'h6b, 7'h6c, 7'h6d, 7'h6e, 7'h6f, 7'h70,
    7'h71, 7'h72, 7'h00, 7'h00, 7'h2d, 7'h29, 7'h5c, 7'h28,
    7'h00, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h69, 7'h7b, 7'h2e, 7'h7d, 7'h08, 7'h00, 7'h0d,
    7'h20, 7'h22, 7'h27, 7'h7e, 7'h23, 7'h21, 7'h26, 7'h3c,
    7'h3e, 7'h5e, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h60, 7'h3f, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
    7'h59, 7'h5a, 7'h00, 7'h3d, 7'h00, 7'h00, 7'h09, 7'h00,
    7'h5f, 7'h4a, 7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h4f, 7'h50,
    7'h51, 7'h52, 7'h00, 7'h00, 7'h2b, 7'h5d, 7'h7c, 7'h5b,
    7'h00, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
    7'h48, 7'h49, 7'h7b, 7'h2a, 7'h7d, 7'h08, 7'h00, 7'h0d
  };

endpackage

// ----- hdl/fiodec_ifs.sv -----
// ----------------------------------------------------------------------------
// fiodec translator channels
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------

// input item channel
interface fiodec_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [6:0] code;

  modport source (output valid, output op, output code, input ready);
  modport sink (input valid, input op, input code, output ready);
endinterface

// result item channel
interface fiodec_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [6:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

// ----- hdl/fiodec_ascii_case_shift_translator.sv -----
// An input beat reaches its first result beat via the input and result registers.
// Throughput: one item per cycle when out_ch is ready; a two-result item holds the
//   input until the single result register takes its second result from the hold.
// Items with no result still take one pass through the input register.
// Reset (synchronous, rst_n low) empties all stages and selects lower case.
// ----------------------------------------------------------------------------
// fiodec ascii case shift translator
// keyboard ascii to fiodec with case shifts, fiodec to ascii for the printer
// ----------------------------------------------------------------------------
`include "fiodec_ascii_case_shift_translator_macros.svh"

module fiodec_ascii_case_shift_translator (
  input  logic clk,
  input  logic rst_n,
  fiodec_in_if.sink    in_ch,
  fiodec_out_if.source out_ch
);

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic       in_op_r;
  logic [6:0] in_code_r;

  // case bit
  logic upper_r, upper_nxt;

  // result register and held second result
  logic               out_vld_r, out_vld_nxt;
  logic               sec_vld_r, sec_vld_nxt;
  fiodec_pkg::result_t out_r, out_nxt;
  fiodec_pkg::result_t sec_r, sec_nxt;

  // translation of the registered item
  fiodec_pkg::result_t r0, r1;
  logic [1:0] n_res;
  logic       proc_upper;
  logic [6:0] key;
  logic [7:0] ent;
  logic [5:0] fc;
  logic [6:0] ch;

  logic adv, go, in_ready;

  // terms used by the checks
  logic chk_pair_last, chk_key_pair, chk_up_code, chk_shift_code, chk_key_shift;

  // stage advance control
  assign adv      = !sec_vld_r && (!out_vld_r || out_ch.ready);
  assign go       = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;
  assign in_ch.ready = in_ready;

  // translate one item
  always_comb begin
    key        = (in_code_r == fiodec_pkg::KEY_RUBOUT) ? fiodec_pkg::KEY_BACKSPACE
                                                       : in_code_r;
    ent        = fiodec_pkg::KEY_ROM[key];
    fc         = in_code_r[5:0];
    ch         = fiodec_pkg::PRINT_ROM[{upper_r, fc}];
    proc_upper = upper_r;
    n_res      = 2'd0;
    r0         = '{kind: fiodec_pkg::KIND_FIODEC, value: 7'd0, last: 1'b1};
    r1         = '{kind: fiodec_pkg::KIND_FIODEC, value: 7'd0, last: 1'b1};
    case (in_op_r)
      fiodec_pkg::OP_KEY: begin
        if (ent == 8'd0) begin
          n_res = 2'd0;
        end else if (ent[fiodec_pkg::KEY_ANY_BIT] ||
                     (ent[fiodec_pkg::KEY_UP_BIT] == upper_r)) begin
          n_res = 2'd1;
          r0    = '{kind: fiodec_pkg::KIND_FIODEC, value: {1'b0, ent[5:0]}, last: 1'b1};
        end else begin
          n_res      = 2'd2;
          proc_upper = ent[fiodec_pkg::KEY_UP_BIT];
          r0 = '{kind: fiodec_pkg::KIND_FIODEC,
                 value: {1'b0, ent[fiodec_pkg::KEY_UP_BIT] ? fiodec_pkg::SHIFT_UP_CODE
                                                           : fiodec_pkg::SHIFT_DOWN_CODE},
                 last: 1'b0};
          r1 = '{kind: fiodec_pkg::KIND_FIODEC, value: {1'b0, ent[5:0]}, last: 1'b1};
        end
      end
      fiodec_pkg::OP_PRINT: begin
        if (fc == fiodec_pkg::SHIFT_UP_CODE) begin
          proc_upper = 1'b1;
        end else if (fc == fiodec_pkg::SHIFT_DOWN_CODE) begin
          proc_upper = 1'b0;
        end else if (ch == 7'd0) begin
          n_res = 2'd0;
        end else if (ch == fiodec_pkg::CHAR_CR) begin
          n_res = 2'd2;
          r0    = '{kind: fiodec_pkg::KIND_ASCII, value: fiodec_pkg::CHAR_CR, last: 1'b0};
          r1    = '{kind: fiodec_pkg::KIND_ASCII, value: fiodec_pkg::CHAR_LF, last: 1'b1};
        end else begin
          n_res = 2'd1;
          r0    = '{kind: fiodec_pkg::KIND_ASCII, value: ch, last: 1'b1};
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

  // next values of the stage control and payload
  always_comb begin
    in_vld_nxt  = in_ready ? in_ch.valid : in_vld_r;
    upper_nxt   = go ? proc_upper : upper_r;
    out_vld_nxt = out_vld_r;
    sec_vld_nxt = sec_vld_r;
    out_nxt     = out_r;
    sec_nxt     = sec_r;
    if (go) begin
      out_vld_nxt = (n_res != 2'd0);
      sec_vld_nxt = (n_res == 2'd2);
      out_nxt     = r0;
      sec_nxt     = r1;
    end else if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = sec_vld_r;
      sec_vld_nxt = 1'b0;
      out_nxt     = sec_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sec_vld_r <= 1'b0;
      upper_r   <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      sec_vld_r <= sec_vld_nxt;
      upper_r   <= upper_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_op_r   <= in_ch.op;
      in_code_r <= in_ch.code;
    end
    out_r <= out_nxt;
    sec_r <= sec_nxt;
  end

  // result port
  assign out_ch.valid = out_vld_r;
  assign out_ch.kind  = out_r.kind;
  assign out_ch.value = out_r.value;
  assign out_ch.last  = out_r.last;

  // check terms
  assign chk_pair_last  = !out_r.last && sec_r.last;
  assign chk_key_pair   = sec_vld_r && (out_r.kind == fiodec_pkg::KIND_FIODEC);
  assign chk_up_code    = (out_r.value[5:0] == fiodec_pkg::SHIFT_UP_CODE);
  assign chk_shift_code = chk_up_code || (out_r.value[5:0] == fiodec_pkg::SHIFT_DOWN_CODE);
  assign chk_key_shift  = go && (n_res == 2'd2) && (in_op_r == fiodec_pkg::OP_KEY);

  // checks
  `FIODEC_ASSERT_IMP(a_sec_has_first, clk, rst_n, sec_vld_r, out_vld_r, "second without first")
  `FIODEC_ASSERT_IMP(a_first_not_last, clk, rst_n, sec_vld_r, chk_pair_last, "pair last marks wrong")
  `FIODEC_ASSERT_IMP(a_pair_kind, clk, rst_n, sec_vld_r, sec_r.kind == out_r.kind, "pair kinds differ")
  `FIODEC_ASSERT_IMP(a_key_pair_shift, clk, rst_n, chk_key_pair, chk_shift_code, "no shift code")
  `FIODEC_ASSERT_NXT(a_shift_case, clk, rst_n, chk_key_shift, upper_r == chk_up_code, "case bit wrong")

endmodule
